FILE: hw/rtl/volume_block_sum_downsample_unit_assert.svh
// Assertion macros shared by the block-sum downsampler RTL.
`ifndef VOLUME_BLOCK_SUM_DOWNSAMPLE_UNIT_ASSERT_SVH
`define VOLUME_BLOCK_SUM_DOWNSAMPLE_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define VBSD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("vbsd assertion failed");

// next-cycle implication, off while in reset
`define VBSD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("vbsd assertion failed");

`endif

FILE: hw/rtl/vbsd_pkg.sv
// Types and constants of the block-sum downsampler.
`timescale 1ns / 1ps
package vbsd_pkg;

  localparam int GRAD_W     = 32;
  localparam int SUM_W      = 41;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int DIM_W      = 7;
  localparam int SCALE_W    = 4;
  localparam int CCNT_W     = 17;
  localparam int CHAN_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMALL_DEPTH   = 3'd0,
    REG_SMALL_HEIGHT  = 3'd1,
    REG_SMALL_WIDTH   = 3'd2,
    REG_SCALE         = 3'd3,
    REG_CHANNEL_COUNT = 3'd4
  } cfg_reg_e;

  // position flags of one item, from the sequencer to the datapath
  typedef struct packed {
    logic first;
    logic last;
    logic is_final;
  } pos_flags_t;

endpackage

FILE: hw/rtl/vbsd_ram.sv
// Accumulator plane memory: one write port, one registered read port.
`timescale 1ns / 1ps
module vbsd_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 41
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // read-during-write to the same entry returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/vbsd_seq.sv
// Config registers and position sequencer: block offsets, plane index, flags.
`timescale 1ns / 1ps
module vbsd_seq #(
  parameter int MAX_EDGE  = 64,
  parameter int MAX_SCALE = 8,
  parameter int AW        = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vbsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vbsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             adv_i,
  output logic [AW-1:0]                    idx_o,
  output vbsd_pkg::pos_flags_t             flags_o
);
  import vbsd_pkg::*;

  localparam int EW = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
  localparam int OW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int PW = 2 * EW + 1;

  function automatic logic [EW-1:0] dim_last(input logic [DIM_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v < 1) v = 1;
    if (v > MAX_EDGE) v = MAX_EDGE;
    return EW'(v - 1);
  endfunction

  function automatic logic [OW-1:0] scale_last(input logic [SCALE_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v < 1) v = 1;
    if (v > MAX_SCALE) v = MAX_SCALE;
    return OW'(v - 1);
  endfunction

  logic [DIM_W-1:0]   depth_q, depth_d, height_q, height_d, width_q, width_d;
  logic [SCALE_W-1:0] scale_q, scale_d;
  logic [CCNT_W-1:0]  ccnt_q, ccnt_d;
  logic               cfg_hit;

  logic [OW-1:0]     coff_q, coff_d, roff_q, roff_d, doff_q, doff_d;
  logic [EW-1:0]     scol_q, scol_d, srow_q, srow_d, sdep_q, sdep_d;
  logic [CHAN_W-1:0] chan_q, chan_d;

  logic [EW-1:0]     sd_m1, sh_m1, sw_m1;
  logic [OW-1:0]     sc_m1;
  logic [CHAN_W-1:0] cc_m1;
  logic [EW:0]       sw_val;
  logic [PW-1:0]     row_base;
  logic              c_end, r_end, d_end;
  logic              end_col, end_row, end_dep, end_chan;

  assign sd_m1  = dim_last(depth_q);
  assign sh_m1  = dim_last(height_q);
  assign sw_m1  = dim_last(width_q);
  assign sc_m1  = scale_last(scale_q);
  assign cc_m1  = ccnt_q[CCNT_W-1] ? {CHAN_W{1'b1}} :
                  (ccnt_q == '0) ? '0 : (ccnt_q[CHAN_W-1:0] - 1'b1);
  assign sw_val = {1'b0, sw_m1} + 1'b1;

  assign c_end    = (coff_q == sc_m1);
  assign r_end    = (roff_q == sc_m1);
  assign d_end    = (doff_q == sc_m1);
  assign end_col  = c_end && (scol_q == sw_m1);
  assign end_row  = r_end && (srow_q == sh_m1);
  assign end_dep  = d_end && (sdep_q == sd_m1);
  assign end_chan = (chan_q == cc_m1);

  assign row_base = PW'(srow_q) * PW'(sw_val);
  assign idx_o    = AW'(row_base + PW'(scol_q));

  assign flags_o.first    = (coff_q == '0) && (roff_q == '0) && (doff_q == '0);
  assign flags_o.last     = c_end && r_end && d_end;
  assign flags_o.is_final = end_col && end_row && end_dep && end_chan;

  always_comb begin
    depth_d  = depth_q;
    height_d = height_q;
    width_d  = width_q;
    scale_d  = scale_q;
    ccnt_d   = ccnt_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      cfg_hit = 1'b1;
      case (cfg_reg_e'(cfg_idx_i))
        REG_SMALL_DEPTH:   depth_d  = cfg_wdata_i[DIM_W-1:0];
        REG_SMALL_HEIGHT:  height_d = cfg_wdata_i[DIM_W-1:0];
        REG_SMALL_WIDTH:   width_d  = cfg_wdata_i[DIM_W-1:0];
        REG_SCALE:         scale_d  = cfg_wdata_i[SCALE_W-1:0];
        REG_CHANNEL_COUNT: ccnt_d   = cfg_wdata_i[CCNT_W-1:0];
        default:           cfg_hit  = 1'b0;
      endcase
    end
  end

  // column, then row, then depth, then channel
  always_comb begin
    coff_d = coff_q;
    roff_d = roff_q;
    doff_d = doff_q;
    scol_d = scol_q;
    srow_d = srow_q;
    sdep_d = sdep_q;
    chan_d = chan_q;
    if (cfg_hit) begin
      coff_d = '0;
      roff_d = '0;
      doff_d = '0;
      scol_d = '0;
      srow_d = '0;
      sdep_d = '0;
      chan_d = '0;
    end else if (adv_i) begin
      if (!c_end) begin
        coff_d = coff_q + 1'b1;
      end else begin
        coff_d = '0;
        if (!end_col) begin
          scol_d = scol_q + 1'b1;
        end else begin
          scol_d = '0;
          if (!r_end) begin
            roff_d = roff_q + 1'b1;
          end else begin
            roff_d = '0;
            if (!end_row) begin
              srow_d = srow_q + 1'b1;
            end else begin
              srow_d = '0;
              if (!d_end) begin
                doff_d = doff_q + 1'b1;
              end else begin
                doff_d = '0;
                if (!end_dep) begin
                  sdep_d = sdep_q + 1'b1;
                end else begin
                  sdep_d = '0;
                  chan_d = end_chan ? '0 : (chan_q + 1'b1);
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      width_q  <= DIM_W'(1);
      scale_q  <= SCALE_W'(2);
      ccnt_q   <= CCNT_W'(1);
      coff_q   <= '0;
      roff_q   <= '0;
      doff_q   <= '0;
      scol_q   <= '0;
      srow_q   <= '0;
      sdep_q   <= '0;
      chan_q   <= '0;
    end else begin
      depth_q  <= depth_d;
      height_q <= height_d;
      width_q  <= width_d;
      scale_q  <= scale_d;
      ccnt_q   <= ccnt_d;
      coff_q   <= coff_d;
      roff_q   <= roff_d;
      doff_q   <= doff_d;
      scol_q   <= scol_d;
      srow_q   <= srow_d;
      sdep_q   <= sdep_d;
      chan_q   <= chan_d;
    end
  end

endmodule

FILE: hw/rtl/volume_block_sum_downsample_unit.sv
// Block-sum downsampler top level: sequencer, plane memory, accumulate stage.
// Throughput: one item per cycle; a stall only arises when a block sum
//   cannot leave because the output register is full and stalled.
// Path: the last item of a block is read from memory on accept and held in the
//   accumulate stage, which adds, writes back and fills the output register.
// Reset: control state and config registers reset; the plane memory does not.
`timescale 1ns / 1ps
`include "volume_block_sum_downsample_unit_assert.svh"
module volume_block_sum_downsample_unit #(
  parameter int MAX_EDGE    = 64,
  parameter int MAX_SCALE   = 8,
  parameter int PLANE_WORDS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [vbsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vbsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [vbsd_pkg::GRAD_W-1:0] grad_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [vbsd_pkg::SUM_W-1:0] block_sum_o,
  output logic                             final_res_o
);
  import vbsd_pkg::*;

  localparam int AW = (PLANE_WORDS > 1) ? $clog2(PLANE_WORDS) : 1;

  logic              in_acc;
  logic [AW-1:0]     seq_idx;
  pos_flags_t        seq_flags;
  logic [SUM_W-1:0]  rd_data;

  logic              b_valid_q;
  logic [AW-1:0]     b_idx_q;
  pos_flags_t        b_flags_q;
  logic [GRAD_W-1:0] b_grad_q;

  logic              wr_valid_q;
  logic [AW-1:0]     wr_idx_q;
  logic [SUM_W-1:0]  wr_data_q;

  logic              out_valid_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic              out_final_q;

  logic              out_free, b_move;
  logic [SUM_W-1:0]  grad_ext, operand, sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign b_move     = !b_valid_q || !b_flags_q.last || out_free;
  assign in_stall_o = !b_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  vbsd_seq #(
    .MAX_EDGE  (MAX_EDGE),
    .MAX_SCALE (MAX_SCALE),
    .AW        (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (in_acc),
    .idx_o       (seq_idx),
    .flags_o     (seq_flags)
  );

  vbsd_ram #(
    .DEPTH (PLANE_WORDS),
    .AW    (AW),
    .DW    (SUM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (b_valid_q && b_move),
    .waddr_i (b_idx_q),
    .wdata_i (sum),
    .re_i    (in_acc),
    .raddr_i (seq_idx),
    .rdata_o (rd_data)
  );

  // the write landing on the read edge is not seen by the memory: forward it
  assign grad_ext = {{(SUM_W - GRAD_W){b_grad_q[GRAD_W-1]}}, b_grad_q};
  assign operand  = (wr_valid_q && (wr_idx_q == b_idx_q)) ? wr_data_q : rd_data;
  assign sum      = b_flags_q.first ? grad_ext : (operand + grad_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      wr_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (b_move) begin
        b_valid_q  <= in_acc;
        wr_valid_q <= b_valid_q;
      end
      if (b_valid_q && b_flags_q.last && b_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_idx_q   <= seq_idx;
      b_flags_q <= seq_flags;
      b_grad_q  <= grad_i;
    end
    if (b_move) begin
      wr_idx_q  <= b_idx_q;
      wr_data_q <= sum;
    end
    if (b_valid_q && b_flags_q.last && b_move) begin
      out_sum_q   <= sum;
      out_final_q <= b_flags_q.is_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_sum_o = out_sum_q;
  assign final_res_o = out_final_q;

  `VBSD_ASSERT_IMP(a_stall_only_on_blocked_sum, clk_i, rst_ni, in_stall_o, b_valid_q && b_flags_q.last && out_valid_q && out_stall_i)
  `VBSD_ASSERT_NXT(a_accept_fills_stage, clk_i, rst_ni, in_valid_i && !in_stall_o, b_valid_q)
  `VBSD_ASSERT_NXT(a_result_held, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q && $stable(out_sum_q) && $stable(out_final_q))

endmodule

FILE: test/volume_block_sum_downsample_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the block-sum downsampler: random volumes, stalls, own sum predictor.
module volume_block_sum_downsample_unit_test;
  import vbsd_pkg::*;

  localparam int unsigned EDGE_MAX    = 64;
  localparam int unsigned SCALE_MAX   = 8;
  localparam int unsigned CHAN_MAX    = 65536;
  localparam int unsigned WORDS       = 4096;
  localparam int unsigned ITEM_GOAL   = 1750;
  localparam int unsigned BATCH_CAP   = 400;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 22;
  localparam logic signed [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef enum int {GRAD_ANY, GRAD_SMALL, GRAD_EDGE, GRAD_TOP, GRAD_BOTTOM} grad_mix_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    fin;
  } block_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i = '0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [GRAD_W-1:0] grad_i      = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [SUM_W-1:0]  block_sum_o;
  logic                     final_res_o;

  logic signed [GRAD_W-1:0] grad_q[$];
  block_result_t            sum_exp_q[$];
  bit                       calm       = 1'b0;
  int unsigned              mismatches = 0;
  longint unsigned          items_sent = 0;
  int unsigned              cycles     = 0;

  // predictor: partial sums of the current plane, walk position, raw registers
  logic signed [SUM_W-1:0] plane_sum [WORDS];
  int unsigned col_at, row_at, dep_at, chan_at;
  int unsigned reg_depth, reg_height, reg_width, reg_scale, reg_chans;

  volume_block_sum_downsample_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .grad_i      (grad_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .block_sum_o (block_sum_o),
    .final_res_o (final_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                       input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned batch_len(input int unsigned d, input int unsigned h,
                                                input int unsigned w, input int unsigned s,
                                                input int unsigned c);
    longint unsigned sc;
    sc = clip(s, 1, SCALE_MAX);
    return clip(d, 1, EDGE_MAX) * clip(h, 1, EDGE_MAX) * clip(w, 1, EDGE_MAX) *
           sc * sc * sc * clip(c, 1, CHAN_MAX);
  endfunction

  function automatic void restart_walk();
    col_at  = 0;
    row_at  = 0;
    dep_at  = 0;
    chan_at = 0;
  endfunction

  function automatic void take_config(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SMALL_DEPTH: begin
        reg_depth = data[DIM_W-1:0];
        restart_walk();
      end
      REG_SMALL_HEIGHT: begin
        reg_height = data[DIM_W-1:0];
        restart_walk();
      end
      REG_SMALL_WIDTH: begin
        reg_width = data[DIM_W-1:0];
        restart_walk();
      end
      REG_SCALE: begin
        reg_scale = data[SCALE_W-1:0];
        restart_walk();
      end
      REG_CHANNEL_COUNT: begin
        reg_chans = data[CCNT_W-1:0];
        restart_walk();
      end
      default: ;
    endcase
  endfunction

  // adds one gradient into its block; the block's last item yields the sum
  function automatic void fold_grad(input logic signed [GRAD_W-1:0] g);
    int unsigned sd, sh, sw, sc, cc, idx;
    bit first, last, end_col, end_row, end_dep, end_chan;
    logic signed [SUM_W-1:0] g_ext;
    block_result_t res;
    sd = clip(reg_depth, 1, EDGE_MAX);
    sh = clip(reg_height, 1, EDGE_MAX);
    sw = clip(reg_width, 1, EDGE_MAX);
    sc = clip(reg_scale, 1, SCALE_MAX);
    cc = clip(reg_chans, 1, CHAN_MAX);
    g_ext = g;
    idx = ((row_at / sc) * sw + col_at / sc) % WORDS;
    first = (dep_at % sc == 0) && (row_at % sc == 0) && (col_at % sc == 0);
    last = (dep_at % sc == sc - 1) && (row_at % sc == sc - 1) && (col_at % sc == sc - 1);
    end_col = col_at + 1 >= sw * sc;
    end_row = row_at + 1 >= sh * sc;
    end_dep = dep_at + 1 >= sd * sc;
    end_chan = chan_at + 1 >= cc;
    plane_sum[idx] = first ? g_ext : plane_sum[idx] + g_ext;
    if (last) begin
      res.sum = plane_sum[idx];
      res.fin = end_col && end_row && end_dep && end_chan;
      sum_exp_q.push_back(res);
    end
    if (!end_col) begin
      col_at++;
    end else begin
      col_at = 0;
      if (!end_row) begin
        row_at++;
      end else begin
        row_at = 0;
        if (!end_dep) begin
          dep_at++;
        end else begin
          dep_at = 0;
          chan_at = end_chan ? 0 : ((chan_at + 1) & 16'hFFFF);
        end
      end
    end
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < 100) $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (grad_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        grad_i     <= grad_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // prediction and comparison
  always @(posedge clk_i) begin
    block_result_t want;
    if (!rst_ni) begin
      reg_depth  = 1;
      reg_height = 1;
      reg_width  = 1;
      reg_scale  = 2;
      reg_chans  = 1;
      restart_walk();
    end else begin
      if (cfg_we_i) take_config(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) fold_grad(grad_i);
      if (out_valid_o && !out_stall_i) begin
        if (sum_exp_q.size() == 0) begin
          note_mismatch($sformatf("block sum %0d with none pending", block_sum_o));
        end else begin
          want = sum_exp_q.pop_front();
          if (block_sum_o !== want.sum)
            note_mismatch($sformatf("block_sum %0d, want %0d", block_sum_o, want.sum));
          if (final_res_o !== want.fin)
            note_mismatch($sformatf("final_res %0b, want %0b", final_res_o, want.fin));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("volume_block_sum_downsample_unit_test failed");
      $finish;
    end
  end

  function automatic logic signed [GRAD_W-1:0] pick_grad(input grad_mix_e mix);
    case (mix)
      GRAD_SMALL:  return int'($urandom_range(0, 16)) - 8;
      GRAD_EDGE:   return $urandom_range(0, 1) ? GRAD_MAX : GRAD_MIN;
      GRAD_TOP:    return GRAD_MAX;
      GRAD_BOTTOM: return GRAD_MIN;
      default:     return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_dim();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 3);
  endfunction

  task automatic queue_items(input longint unsigned n, input grad_mix_e mix);
    for (longint unsigned i = 0; i < n; i++) grad_q.push_back(pick_grad(mix));
    items_sent += n;
  endtask

  // all items in, all sums out, then a wait for the pipeline to settle
  task automatic drain();
    while (grad_q.size() != 0 || in_valid_i || sum_exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic program_volume(input int unsigned d, input int unsigned h,
                                input int unsigned w, input int unsigned s,
                                input int unsigned c);
    drain();
    write_reg(REG_SMALL_DEPTH, d);
    write_reg(REG_SMALL_HEIGHT, h);
    write_reg(REG_SMALL_WIDTH, w);
    write_reg(REG_SCALE, s);
    write_reg(REG_CHANNEL_COUNT, c);
    @(negedge clk_i);
  endtask

  task automatic run_volume(input int unsigned d, input int unsigned h, input int unsigned w,
                            input int unsigned s, input int unsigned c,
                            input int unsigned batches, input grad_mix_e mix);
    program_volume(d, h, w, s, c);
    queue_items(batch_len(d, h, w, s, c) * batches, mix);
  endtask

  initial begin
    int unsigned d, h, w, s, c, batches;
    longint unsigned len;
    bit cut;
    grad_mix_e mix;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: one 2x2x2 block per batch
    for (int i = 0; i < 8; i++) grad_q.push_back(GRAD_MAX);
    for (int i = 0; i < 8; i++) grad_q.push_back(GRAD_MIN);
    grad_q.push_back(0);
    grad_q.push_back(1);
    grad_q.push_back(-1);
    grad_q.push_back(GRAD_MAX);
    grad_q.push_back(GRAD_MIN);
    grad_q.push_back(32'sh5555_5555);
    grad_q.push_back(32'shAAAA_AAAA);
    grad_q.push_back(-2);
    items_sent += 24;

    run_volume(2, 3, 2, 1, 2, 1, GRAD_ANY);

    // largest blocks at both extremes of the sum, no idling on either side
    calm = 1'b1;
    run_volume(1, 1, 1, SCALE_MAX, 1, 1, GRAD_BOTTOM);
    run_volume(1, 1, 1, 15, 1, 1, GRAD_TOP);
    drain();
    calm = 1'b0;

    // zero registers count as one
    run_volume(0, 0, 0, 0, 0, 10, GRAD_ANY);
    run_volume(127, 1, 1, 1, 1, 1, GRAD_EDGE);

    // sender holds off mid-batch until every pending sum has left
    program_volume(1, 127, 2, 1, 1);
    queue_items(64, GRAD_ANY);
    drain();
    queue_items(64, GRAD_ANY);

    // channel count beyond range, then the top of the range; batches left unfinished
    program_volume(1, 1, 127, 1, 17'h1FFFF);
    queue_items(150, GRAD_ANY);
    program_volume(1, 1, 2, 2, CHAN_MAX);
    queue_items(100, GRAD_SMALL);

    while (items_sent < ITEM_GOAL) begin
      cut = ($urandom_range(0, 4) == 0);
      do begin
        d = pick_dim();
        h = pick_dim();
        w = pick_dim();
        s = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
        c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17'h1FFFF) : $urandom_range(1, 3);
        len = batch_len(d, h, w, s, c);
      end while (batch_len(d, h, w, s, 1) > BATCH_CAP || (!cut && len > BATCH_CAP));
      mix = ($urandom_range(0, 2) == 0) ? grad_mix_e'($urandom_range(0, 4)) : GRAD_ANY;
      program_volume(d, h, w, s, c);
      if (cut) begin
        // stop at a random point of the batch, at most its end; the next write restarts the walk
        queue_items($urandom_range(1, 32'((len < BATCH_CAP) ? len : BATCH_CAP)), mix);
      end else begin
        batches = $urandom_range(1, 3);
        queue_items(len * batches, mix);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("volume_block_sum_downsample_unit_test passed");
    end else begin
      $display("volume_block_sum_downsample_unit_test failed");
    end
    $finish;
  end

endmodule
